// File: rtl/sbp_pkg.sv
package sbp_pkg;

    localparam int FRAC_DEF = 8;
    localparam int CFG_W    = 13;
    localparam int QW       = 24;   // quotient bits per divider

    localparam logic [CFG_W-1:0] WID_RST = 13'd640;
    localparam logic [CFG_W-1:0] HGT_RST = 13'd480;

    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic [32:0] dist2;
        logic        det_nz;
        logic        depth_neg;
        logic        ctr_neg;
    } t_side;

endpackage

// File: rtl/sbp_if.sv
interface sbp_in_if;
    logic               valid;
    logic               ready;
    logic        [15:0] sprite_pos_x;
    logic        [15:0] sprite_pos_y;
    logic        [15:0] viewer_pos_x;
    logic        [15:0] viewer_pos_y;
    logic signed [15:0] view_dir_x;
    logic signed [15:0] view_dir_y;
    logic signed [15:0] view_plane_x;
    logic signed [15:0] view_plane_y;

    modport source(output valid, sprite_pos_x, sprite_pos_y, viewer_pos_x, viewer_pos_y,
                   view_dir_x, view_dir_y, view_plane_x, view_plane_y, input ready);
    modport sink(input valid, sprite_pos_x, sprite_pos_y, viewer_pos_x, viewer_pos_y,
                 view_dir_x, view_dir_y, view_plane_x, view_plane_y, output ready);
endinterface

interface sbp_out_if;
    logic               valid;
    logic               ready;
    logic               visible;
    logic        [32:0] distance_squared;
    logic signed [23:0] depth;
    logic signed [15:0] column_center;
    logic        [15:0] sprite_size;
    logic signed [15:0] first_column;
    logic signed [15:0] last_column;
    logic signed [15:0] first_row;
    logic signed [15:0] last_row;

    modport source(output valid, visible, distance_squared, depth, column_center,
                   sprite_size, first_column, last_column, first_row, last_row,
                   input ready);
    modport sink(input valid, visible, distance_squared, depth, column_center,
                 sprite_size, first_column, last_column, first_row, last_row,
                 output ready);
endinterface

// File: rtl/sprite_billboard_projection_top.sv
// Registered path: stages A, B, C, D, the divider stages, then E and F.
// Throughput: one sprite per cycle; the whole pipe advances whenever the
// output register is empty or its result is being transferred.
// Reset (synchronous, active low): all valid bits cleared, screen width
// and height return to 640 and 480.
module sprite_billboard_projection_top
    import sbp_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    sbp_in_if.sink           i_in,
    sbp_out_if.source        o_out
);

    localparam int SNW = CFG_W + 33 + FRAC_BITS;   // size numerator width

    // Frame size registers
    logic [CFG_W-1:0] r_wid, r_hgt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wid <= WID_RST;
            r_hgt <= HGT_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                REG_WIDTH:  r_wid <= i_cfg_data;
                REG_HEIGHT: r_hgt <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Global advance: stall only when the output holds an untaken result.
    logic en;
    logic r_vld_a, r_vld_b, r_vld_c, r_vld_d, r_vld_e, r_vld_f;
    logic r_vld_q [QW+1];

    assign en         = !r_vld_f || o_out.ready;
    assign i_in.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
            r_vld_c <= 1'b0;
            r_vld_d <= 1'b0;
            r_vld_e <= 1'b0;
            r_vld_f <= 1'b0;
            for (int k = 0; k <= QW; k++) r_vld_q[k] <= 1'b0;
        end else if (en) begin
            r_vld_a    <= i_in.valid;
            r_vld_b    <= r_vld_a;
            r_vld_c    <= r_vld_b;
            r_vld_d    <= r_vld_c;
            r_vld_q[0] <= r_vld_d;
            for (int k = 1; k <= QW; k++) r_vld_q[k] <= r_vld_q[k-1];
            r_vld_e    <= r_vld_q[QW];
            r_vld_f    <= r_vld_e;
        end
    end

    // ---- Stage A: relative position and all products ----
    logic signed [16:0] n_sx, n_sy;
    logic signed [33:0] n_pxx, n_pyy, n_pd1, n_pd2, n_pn1, n_pn2, n_pm1, n_pm2;
    logic signed [33:0] r_pxx, r_pyy, r_pd1, r_pd2, r_pn1, r_pn2, r_pm1, r_pm2;

    always_comb begin
        n_sx  = $signed({1'b0, i_in.sprite_pos_x}) - $signed({1'b0, i_in.viewer_pos_x});
        n_sy  = $signed({1'b0, i_in.sprite_pos_y}) - $signed({1'b0, i_in.viewer_pos_y});
        n_pxx = n_sx * n_sx;
        n_pyy = n_sy * n_sy;
        n_pd1 = i_in.view_plane_x * i_in.view_dir_y;
        n_pd2 = i_in.view_dir_x * i_in.view_plane_y;
        n_pn1 = i_in.view_dir_y * n_sx;
        n_pn2 = i_in.view_dir_x * n_sy;
        n_pm1 = i_in.view_plane_x * n_sy;
        n_pm2 = i_in.view_plane_y * n_sx;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pxx <= n_pxx;
            r_pyy <= n_pyy;
            r_pd1 <= n_pd1;
            r_pd2 <= n_pd2;
            r_pn1 <= n_pn1;
            r_pn2 <= n_pn2;
            r_pm1 <= n_pm1;
            r_pm2 <= n_pm2;
        end
    end

    // ---- Stage B: distance, determinant, camera-space coordinates ----
    logic        [32:0] r_dist2_b;
    logic signed [34:0] r_det, r_nx, r_ny;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dist2_b <= 33'(r_pxx) + 33'(r_pyy);
            r_det     <= 35'(r_pd1) - 35'(r_pd2);
            r_nx      <= 35'(r_pn1) - 35'(r_pn2);
            r_ny      <= 35'(r_pm1) - 35'(r_pm2);
        end
    end

    // ---- Stage C: magnitudes and signs ----
    logic signed [35:0] n_s;
    logic        [32:0] r_det_abs;
    logic        [33:0] r_ny_abs;
    logic        [34:0] r_s_abs;
    logic               r_det_neg, r_ny_neg, r_s_neg, r_det_nz_c;
    logic        [32:0] r_dist2_c;

    assign n_s = 36'(r_nx) + 36'(r_ny);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_det_abs  <= r_det[34] ? 33'(-r_det) : 33'(r_det);
            r_ny_abs   <= r_ny[34]  ? 34'(-r_ny)  : 34'(r_ny);
            r_s_abs    <= n_s[35]   ? 35'(-n_s)   : 35'(n_s);
            r_det_neg  <= r_det[34];
            r_ny_neg   <= r_ny[34];
            r_s_neg    <= n_s[35];
            r_det_nz_c <= (r_det != '0);
            r_dist2_c  <= r_dist2_b;
        end
    end

    // ---- Stage D: divider operands ----
    // depth  = |ny| * 2^14 / |det|
    // center = (W/2) * |nx + ny| / |ny|
    // size   = H * |det| * 2^FRAC / (|ny| * 2^14)
    logic [47:0]    r_dnum;
    logic [32:0]    r_dden;
    logic [46:0]    r_cnum;
    logic [33:0]    r_cden;
    logic [SNW-1:0] r_snum;
    logic [47:0]    r_sden;
    t_side          r_side_d;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dnum             <= {r_ny_abs, 14'd0};
            r_dden             <= r_det_abs;
            r_cnum             <= 47'(r_wid[CFG_W-1:1]) * 47'(r_s_abs);
            r_cden             <= r_ny_abs;
            r_snum             <= (SNW'(r_hgt) * SNW'(r_det_abs)) << FRAC_BITS;
            r_sden             <= {r_ny_abs, 14'd0};
            r_side_d.dist2     <= r_dist2_c;
            r_side_d.det_nz    <= r_det_nz_c;
            r_side_d.depth_neg <= r_ny_neg ^ r_det_neg;
            r_side_d.ctr_neg   <= r_s_neg ^ r_ny_neg;
        end
    end

    // ---- Divider stages, sideband travels alongside ----
    logic [QW-1:0] d_q, c_q, s_q;
    logic          d_ovf, c_ovf, s_ovf;
    t_side         r_side [QW+1];

    sbp_div #(.NW(48), .DW(33)) u_div_depth (
        .i_clk(i_clk), .i_en(en), .i_num(r_dnum), .i_den(r_dden),
        .o_quo(d_q), .o_ovf(d_ovf)
    );

    sbp_div #(.NW(47), .DW(34)) u_div_center (
        .i_clk(i_clk), .i_en(en), .i_num(r_cnum), .i_den(r_cden),
        .o_quo(c_q), .o_ovf(c_ovf)
    );

    sbp_div #(.NW(SNW), .DW(48)) u_div_size (
        .i_clk(i_clk), .i_en(en), .i_num(r_snum), .i_den(r_sden),
        .o_quo(s_q), .o_ovf(s_ovf)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= r_side_d;
            for (int k = 1; k <= QW; k++) r_side[k] <= r_side[k-1];
        end
    end

    // ---- Stage E: sign, saturation, special cases ----
    t_side              sd;
    logic               dmag_nz, proj_ok;
    logic signed [23:0] n_depth;
    logic signed [15:0] n_ctr;
    logic        [15:0] n_size;

    logic               r_vis_e;
    logic        [32:0] r_dist2_e;
    logic signed [23:0] r_depth_e;
    logic signed [15:0] r_ctr_e;
    logic        [15:0] r_size_e;

    assign sd      = r_side[QW];
    assign dmag_nz = d_ovf || (d_q != '0);
    assign proj_ok = sd.det_nz && dmag_nz;

    always_comb begin
        // depth clamps to 24-bit signed
        if (!sd.det_nz) begin
            n_depth = '0;
        end else if (!sd.depth_neg) begin
            n_depth = (d_ovf || d_q[QW-1]) ? 24'sh7FFFFF : $signed(24'(d_q));
        end else if (d_ovf || (d_q > (QW'(1) << 23))) begin
            n_depth = 24'sh800000;
        end else begin
            n_depth = -$signed(24'(d_q));
        end

        // center column clamps to 16-bit signed
        if (!proj_ok) begin
            n_ctr = '0;
        end else if (!sd.ctr_neg) begin
            n_ctr = (c_ovf || (c_q > QW'(32767))) ? 16'sh7FFF : $signed(16'(c_q));
        end else if (c_ovf || (c_q > QW'(32768))) begin
            n_ctr = 16'sh8000;
        end else begin
            n_ctr = 16'(-$signed(17'(c_q)));
        end

        if (!proj_ok) begin
            n_size = '0;
        end else begin
            n_size = (s_ovf || (s_q > QW'(65535))) ? 16'hFFFF : 16'(s_q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_vis_e   <= proj_ok && !sd.depth_neg;
            r_dist2_e <= sd.dist2;
            r_depth_e <= n_depth;
            r_ctr_e   <= n_ctr;
            r_size_e  <= n_size;
        end
    end

    // ---- Stage F: draw bounds, output register ----
    logic        [14:0] half;
    logic signed [17:0] n_c0, n_c1, n_r0, n_r1, wid_s, hgt_s;

    logic               r_vis_f;
    logic        [32:0] r_dist2_f;
    logic signed [23:0] r_depth_f;
    logic signed [15:0] r_ctr_f, r_c0_f, r_c1_f, r_r0_f, r_r1_f;
    logic        [15:0] r_size_f;

    always_comb begin
        half  = r_size_e[15:1];
        wid_s = $signed({5'd0, r_wid});
        hgt_s = $signed({5'd0, r_hgt});
        n_c0  = 18'(r_ctr_e) - $signed({3'd0, half});
        n_c1  = 18'(r_ctr_e) + $signed({3'd0, half});
        n_r0  = $signed({6'd0, r_hgt[CFG_W-1:1]}) - $signed({3'd0, half});
        n_r1  = $signed({6'd0, r_hgt[CFG_W-1:1]}) + $signed({3'd0, half});
        if (n_c0 < 0)      n_c0 = '0;
        if (n_c1 >= wid_s) n_c1 = wid_s - 18'sd1;
        if (n_r0 < 0)      n_r0 = '0;
        if (n_r1 >= hgt_s) n_r1 = hgt_s - 18'sd1;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_vis_f   <= r_vis_e;
            r_dist2_f <= r_dist2_e;
            r_depth_f <= r_depth_e;
            r_ctr_f   <= r_ctr_e;
            r_size_f  <= r_size_e;
            r_c0_f    <= 16'(n_c0);
            r_c1_f    <= 16'(n_c1);
            r_r0_f    <= 16'(n_r0);
            r_r1_f    <= 16'(n_r1);
        end
    end

    assign o_out.valid            = r_vld_f;
    assign o_out.visible          = r_vis_f;
    assign o_out.distance_squared = r_dist2_f;
    assign o_out.depth            = r_depth_f;
    assign o_out.column_center    = r_ctr_f;
    assign o_out.sprite_size      = r_size_f;
    assign o_out.first_column     = r_c0_f;
    assign o_out.last_column      = r_c1_f;
    assign o_out.first_row        = r_r0_f;
    assign o_out.last_row         = r_r1_f;

    // A held result must block new transfers.
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld_f && !o_out.ready) |-> !i_in.ready)
        else $error("input taken while output stalled");

    // A visible sprite always has positive depth.
    a_vis_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.visible) |-> (!o_out.depth[23] && o_out.depth != '0))
        else $error("visible sprite without positive depth");

    // Zero depth forces center and size to zero.
    a_zero_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.depth == '0) |->
        (o_out.sprite_size == '0 && o_out.column_center == '0))
        else $error("zero depth with nonzero projection");

    // Left and top bounds are never negative.
    a_first_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !o_out.first_column[15] && !o_out.first_row[15])
        else $error("first bound negative");

endmodule

// File: rtl/sbp_div.sv
// Pipelined restoring divider: QW quotient bits, one per stage, plus an
// overflow check stage (quotient >= 2^QW).
module sbp_div
    import sbp_pkg::*;
#(
    parameter int NW = 48,
    parameter int DW = 33
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quo,
    output logic          o_ovf
);

    logic [NW-1:0] r_rem [QW+1];
    logic [DW-1:0] r_den [QW+1];
    logic [QW-1:0] r_quo [QW+1];
    logic          r_ovf [QW+1];

    logic [NW-1:0] n_rem [QW+1];
    logic [QW-1:0] n_quo [QW+1];

    always_comb begin
        n_rem[0] = i_num;
        n_quo[0] = '0;
        for (int k = 1; k <= QW; k++) begin
            if ((r_rem[k-1] >> (QW - k)) >= NW'(r_den[k-1])) begin
                n_rem[k] = r_rem[k-1] - (NW'(r_den[k-1]) << (QW - k));
                n_quo[k] = r_quo[k-1] | (QW'(1) << (QW - k));
            end else begin
                n_rem[k] = r_rem[k-1];
                n_quo[k] = r_quo[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= n_rem[0];
            r_quo[0] <= n_quo[0];
            r_den[0] <= i_den;
            r_ovf[0] <= (i_num >> QW) >= NW'(i_den);
            for (int k = 1; k <= QW; k++) begin
                r_rem[k] <= n_rem[k];
                r_quo[k] <= n_quo[k];
                r_den[k] <= r_den[k-1];
                r_ovf[k] <= r_ovf[k-1];
            end
        end
    end

    assign o_quo = r_quo[QW];
    assign o_ovf = r_ovf[QW];

endmodule
